// ===== rtl/dwnl_pkg.sv =====
// Package for the DNS wire-name lowercase block.
// Holds the shared phase type, result struct and name-format constants.
`default_nettype none

package dwnl_pkg;

    localparam logic [7:0] LABEL_MAX  = 8'd63;
    localparam logic [7:0] TERMINATOR = 8'd0;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [1:0] PTR_TAG    = 2'b11;

    typedef enum logic {
        PH_LENGTH,
        PH_LABEL
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       status;
        logic       last;
        logic [7:0] total_length;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/dwnl_in_reg.sv =====
// Input register stage of the DNS wire-name lowercase block.
// Holds one source byte until the core takes it; no package dependency.
`default_nettype none

module dwnl_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    input  wire logic       i_take,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Refill in the same cycle the held byte moves on.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// ===== rtl/dwnl_core.sv =====
// Per-byte decision logic and result register of the DNS wire-name lowercase block.
// Depends on dwnl_pkg for the phase type, result struct and constants.
`default_nettype none

module dwnl_core
    import dwnl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_dst_size,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_take,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_result         o_result
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_remaining, n_remaining;
    logic [7:0]  r_written, n_written;
    logic        r_out_valid;
    t_result     r_result, n_result;

    logic [7:0]  lower_byte;
    logic [7:0]  written_inc;
    logic [8:0]  fit_sum;
    logic [5:0]  remaining_dec;

    assign o_take = i_valid && (!r_out_valid || i_ready);

    assign lower_byte    = (i_byte >= UPPER_A && i_byte <= UPPER_Z) ?
                           i_byte + CASE_DELTA : i_byte;
    assign written_inc   = r_written + 8'd1;
    assign fit_sum       = {1'b0, r_written} + 9'd1 + {1'b0, i_byte};
    assign remaining_dec = (r_remaining != 6'd0) ? r_remaining - 6'd1 : 6'd0;

    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_written   = r_written;
        n_result    = '0;
        unique case (r_phase)
            PH_LABEL: begin
                n_result.out_byte = lower_byte;
                n_written         = written_inc;
                n_remaining       = remaining_dec;
                if (remaining_dec == 6'd0) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                priority if (i_byte == TERMINATOR) begin
                    n_phase     = PH_LENGTH;
                    n_remaining = 6'd0;
                    n_written   = 8'd0;
                    n_result.last = 1'b1;
                    if (r_written >= i_dst_size) begin
                        n_result.status = 1'b1;
                    end else begin
                        n_result.total_length = written_inc;
                    end
                end else if (i_byte[7:6] == PTR_TAG || i_byte > LABEL_MAX ||
                             fit_sum >= {1'b0, i_dst_size}) begin
                    // pointer, extended type, or label does not fit: abort
                    n_phase         = PH_LENGTH;
                    n_remaining     = 6'd0;
                    n_written       = 8'd0;
                    n_result.status = 1'b1;
                    n_result.last   = 1'b1;
                end else begin
                    n_phase           = PH_LABEL;
                    n_remaining       = i_byte[5:0];
                    n_written         = written_inc;
                    n_result.out_byte = i_byte;
                end
            end
            default: begin
                n_phase = PH_LENGTH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LENGTH;
            r_remaining <= 6'd0;
            r_written   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase     <= n_phase;
                r_remaining <= n_remaining;
                r_written   <= n_written;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/dns_wire_name_lowercase.sv =====
// DNS wire-name lowercase: one result byte per source byte.
// An input byte passes the input register, then the result register, before o_valid rises.
// Throughput: one byte per cycle while i_ready is high; o_ready follows i_ready through the two registers.
// Reset (synchronous, active low): name state cleared, both stages empty, dst_size = 255.
// Depends on dwnl_pkg, dwnl_in_reg and dwnl_core.
`default_nettype none

module dns_wire_name_lowercase
    import dwnl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_source_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_status,
    output logic            o_last,
    output logic [7:0]      o_total_length
);

    logic [7:0] r_dst_size;
    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       stage_take;
    t_result    result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_size <= 8'd255;
        end else if (i_cfg_wr_en) begin
            r_dst_size <= i_cfg_wr_data;
        end
    end

    dwnl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_source_byte),
        .o_valid (stage_valid),
        .i_take  (stage_take),
        .o_byte  (stage_byte)
    );

    dwnl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dst_size (r_dst_size),
        .i_valid    (stage_valid),
        .i_byte     (stage_byte),
        .o_take     (stage_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (result)
    );

    assign o_out_byte     = result.out_byte;
    assign o_status       = result.status;
    assign o_last         = result.last;
    assign o_total_length = result.total_length;

endmodule

`default_nettype wire

// ===== rtl/dwnl_checker.sv =====
// Port-level checker for dns_wire_name_lowercase, bound to the top level.
// Uses only the top-level ports; no package dependency.
`default_nettype none

module dwnl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_ready,
    input wire logic       o_valid,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_status,
    input wire logic       o_last,
    input wire logic [7:0] o_total_length
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_status)
            && $stable(o_last) && $stable(o_total_length))
        else $error("result changed while stalled");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && o_out_byte == 8'd0 && o_total_length == 8'd0)
        else $error("error result malformed");

    a_mid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_total_length == 8'd0)
        else $error("length reported before end of name");

    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !o_status |-> o_out_byte == 8'd0 && o_total_length != 8'd0)
        else $error("terminator result malformed");

endmodule

bind dns_wire_name_lowercase dwnl_checker u_dwnl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_ready        (i_ready),
    .o_valid        (o_valid),
    .o_out_byte     (o_out_byte),
    .o_status       (o_status),
    .o_last         (o_last),
    .o_total_length (o_total_length)
);

`default_nettype wire

// ===== bench/tb_dns_wire_name_lowercase.sv =====
// Self-checking bench for dns_wire_name_lowercase: wire-format names in, folded bytes out.
// A reference predictor runs on each accepted byte; results are compared field by field.
// Depends on dwnl_pkg and the dns_wire_name_lowercase RTL.
`timescale 1ns / 100ps

module tb_dns_wire_name_lowercase;
    import dwnl_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'd0;
    logic       i_valid = 1'b0;
    logic [7:0] i_source_byte = 8'd0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_status;
    logic       o_last;
    logic [7:0] o_total_length;

    dns_wire_name_lowercase dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_source_byte  (i_source_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_status       (o_status),
        .o_last         (o_last),
        .o_total_length (o_total_length)
    );

    always #5 i_clk = ~i_clk;

    // predictor state, mirrors the block after reset
    t_phase     name_phase = PH_LENGTH;
    logic [5:0] label_left = 6'd0;
    logic [7:0] written = 8'd0;
    logic [7:0] dst_cap = 8'd255;

    logic [7:0] src_bytes_q[$];
    t_result    folded_q[$];
    t_result    head;

    logic rst_done = 1'b0;
    logic calm = 1'b0;
    logic src_taken = 1'b0;
    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   src_gap = 0;
    int   snk_gap = 0;

    int n_queued = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_names = 0;
    int n_aborts = 0;
    int n_folded = 0;
    int n_cfg = 0;

    function automatic t_result fold_name_byte(input logic [7:0] b);
        t_result r;
        logic    bad;
        r = '0;
        bad = 1'b0;
        if (name_phase == PH_LABEL) begin
            r.out_byte = (b >= UPPER_A && b <= UPPER_Z) ? b + CASE_DELTA : b;
            if (r.out_byte != b) n_folded++;
            written = written + 8'd1;
            if (label_left != 6'd0) label_left = label_left - 6'd1;
            if (label_left == 6'd0) name_phase = PH_LENGTH;
        end else if (b == TERMINATOR) begin
            if (written >= dst_cap) begin
                bad = 1'b1;
            end else begin
                r.out_byte = TERMINATOR;
                r.last = 1'b1;
                r.total_length = written + 8'd1;
                n_names++;
                written = 8'd0;
                label_left = 6'd0;
                name_phase = PH_LENGTH;
            end
        end else if (b[7:6] == PTR_TAG || b > LABEL_MAX
                     || int'(written) + 1 + int'(b) >= int'(dst_cap)) begin
            bad = 1'b1;
        end else begin
            written = written + 8'd1;
            label_left = b[5:0];
            name_phase = PH_LABEL;
            r.out_byte = b;
        end
        if (bad) begin
            // aborted name: error result and a fresh name state
            r = '0;
            r.status = 1'b1;
            r.last = 1'b1;
            written = 8'd0;
            label_left = 6'd0;
            name_phase = PH_LENGTH;
            n_aborts++;
        end
        return r;
    endfunction

    task automatic log_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
        n_mismatch++;
        $display("%0t: mismatch on %s, got %h want %h (result %0d)",
                 $time, what, got, want, n_results);
    endtask

    // sender: one transaction at a time from the pending queue
    always @(negedge i_clk) begin
        if (!rst_done) begin
            i_valid <= 1'b0;
        end else if (i_valid && !src_taken) begin
            // hold payload until accepted
        end else if (src_gap > 0) begin
            src_gap--;
            i_valid <= 1'b0;
        end else if (src_bytes_q.size() == 0) begin
            i_valid <= 1'b0;
        end else if (!calm && src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            src_gap = $urandom_range(1, 16) - 1;
            i_valid <= 1'b0;
        end else begin
            i_valid <= 1'b1;
            i_source_byte <= src_bytes_q.pop_front();
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap--;
            i_ready <= 1'b0;
        end else if (!calm && snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
            snk_gap = $urandom_range(1, 16) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        src_taken = i_rst_n && i_valid && o_ready;
        if (src_taken)
            folded_q.push_back(fold_name_byte(i_source_byte));
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (folded_q.size() == 0) begin
                log_mismatch("result with none outstanding", o_out_byte, 8'h00);
            end else begin
                head = folded_q.pop_front();
                if (o_out_byte !== head.out_byte)
                    log_mismatch("out_byte", o_out_byte, head.out_byte);
                if (o_status !== head.status)
                    log_mismatch("status", {7'd0, o_status}, {7'd0, head.status});
                if (o_last !== head.last)
                    log_mismatch("last", {7'd0, o_last}, {7'd0, head.last});
                if (o_total_length !== head.total_length)
                    log_mismatch("total_length", o_total_length, head.total_length);
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        src_bytes_q.push_back(b);
        n_queued++;
    endtask

    // only while nothing is in flight
    task automatic set_dst(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        dst_cap = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (src_bytes_q.size() != 0 || i_valid || folded_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_char();
        logic [7:0] picks[6];
        picks = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return UPPER_A + 8'($urandom_range(0, 25));
            4, 5:       return 8'h61 + 8'($urandom_range(0, 25));
            6:          return picks[$urandom_range(0, 5)];
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_label(input int len, input int chars);
        queue_byte(8'(len));
        repeat (chars) queue_byte(rand_char());
    endtask

    task automatic queue_name(input int labels);
        int len;
        repeat (labels) begin
            len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(1, 10);
            queue_label(len, len);
        end
        queue_byte(TERMINATOR);
    endtask

    initial begin
        int r;
        int len;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        // directed: reset size, empty name, letter boundaries, zero and 0xFF in a label
        queue_byte(TERMINATOR);
        queue_label(5, 0);
        queue_byte(8'h41); queue_byte(8'h5A); queue_byte(8'h40);
        queue_byte(8'h5B); queue_byte(8'h00);
        queue_label(1, 0);
        queue_byte(8'hFF);
        queue_byte(TERMINATOR);
        // pointer, extended label types
        queue_byte(8'hC0);
        queue_byte(8'h40);
        queue_byte(8'hBF);
        queue_byte(8'hFF);
        settle();
        // zero capacity: any first byte aborts
        set_dst(8'd0);
        queue_byte(8'h05);
        queue_byte(TERMINATOR);
        settle();
        // exact fit, then a label that does not fit
        set_dst(8'd4);
        queue_label(2, 0); queue_byte(8'h41); queue_byte(8'h42);
        queue_byte(TERMINATOR);
        queue_byte(8'h03);
        queue_label(1, 0); queue_byte(8'h51); queue_byte(8'h01);
        settle();
        // size shrinks inside an admitted label: chars pass, terminator aborts
        set_dst(8'd255);
        queue_label(2, 0); queue_byte(8'h4D);
        settle();
        set_dst(8'd1);
        queue_byte(8'h4E);
        queue_byte(TERMINATOR);
        settle();
        // size shrinks between labels, terminator still fits
        set_dst(8'd255);
        queue_label(1, 0); queue_byte(8'h78);
        settle();
        set_dst(8'd3);
        queue_byte(TERMINATOR);
        settle();

        // random: mostly well-formed names, some noise and cut-off names
        while (n_queued < 560) begin
            case ($urandom_range(0, 9))
                0:          set_dst(8'd0);
                1:          set_dst(8'($urandom_range(1, 8)));
                2, 3, 4, 5: set_dst(8'd255);
                default:    set_dst(8'($urandom_range(20, 254)));
            endcase
            r = $urandom_range(0, 2);
            src_idle_pct = (r == 0) ? 0 : (r == 1) ? 5 : 25;
            r = $urandom_range(0, 2);
            snk_idle_pct = (r == 0) ? 0 : (r == 1) ? 5 : 25;
            repeat ($urandom_range(3, 10)) begin
                r = $urandom_range(0, 19);
                if (r < 15) begin
                    queue_name($urandom_range(1, 4));
                end else if (r < 17) begin
                    case ($urandom_range(0, 2))
                        0:       queue_byte(8'hC0 | 8'($urandom_range(0, 63)));
                        1:       queue_byte(8'($urandom_range(64, 191)));
                        default: queue_byte(8'($urandom_range(0, 255)));
                    endcase
                end else begin
                    // name cut short inside a label
                    len = $urandom_range(2, 12);
                    queue_label(len, $urandom_range(0, len - 1));
                end
            end
            // sender holds off until the block has drained
            settle();
        end

        // closing stretch with no idling
        calm = 1'b1;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_dst(8'd255);
        repeat (4) queue_name($urandom_range(1, 3));
        settle();
        repeat (10) @(posedge i_clk);
        if (folded_q.size() != 0)
            log_mismatch("results never delivered", 8'(folded_q.size()), 8'h00);

        $display("covered %0d source bytes, %0d size settings: %0d names ended,",
                 n_queued, n_cfg, n_names);
        $display("%0d aborted, %0d letters folded", n_aborts, n_folded);
        if (n_mismatch == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", folded_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dwnl_pkg.sv
rtl/dwnl_in_reg.sv
rtl/dwnl_core.sv
rtl/dns_wire_name_lowercase.sv
rtl/dwnl_checker.sv
bench/tb_dns_wire_name_lowercase.sv
